[design/srfp_pkg.sv]
// ----------------------------------------------------------------------------
// srfp_pkg: shared types and constants of the sensor reply frame parser
// Holds the result beat layout, configuration register indexes and the
// reset values of the header registers.
// ----------------------------------------------------------------------------
`default_nettype none

package srfp_pkg;

   // default upper bound of the length field (payload plus checksum bytes)
   localparam int SRFP_MAX_LENGTH = 256;

   // header reset values
   localparam logic [7:0] HEADER_FIRST_RESET  = 8'hEF;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'h01;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HEADER_FIRST  = 1'b0,
      CSR_HEADER_SECOND = 1'b1
   } csr_index_type;

   // one result beat
   typedef struct packed {
      logic        is_end;
      logic [7:0]  packet_id;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [15:0] payload_length;
      logic        checksum_ok;
      logic        length_error;
   } result_type;

endpackage

`default_nettype wire

[design/srfp_frame_fsm.sv]
// ----------------------------------------------------------------------------
// srfp_frame_fsm: frame state machine of the reply parser
// Tracks header hunt, address skip, id, length, payload and checksum, and
// forms the result for the beat being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module srfp_frame_fsm #(
   parameter int MAX_LENGTH = srfp_pkg::SRFP_MAX_LENGTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step,
   input  wire [7:0]                rx_byte,
   input  wire [7:0]                header_first,
   input  wire [7:0]                header_second,
   output logic                     res_valid,
   output srfp_pkg::result_type     res
);
   import srfp_pkg::*;

   // wide enough for MAX_LENGTH payload bytes
   localparam int CountWidth = $clog2(MAX_LENGTH + 1);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_ADDR    = 3'd1,
      PH_ID      = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            id_ff, id_in;
   logic [15:0]           length_ff, length_in;
   logic [15:0]           sum_ff, sum_in;
   logic [7:0]            check_high_ff, check_high_in;

   logic                  hit_valid;
   logic                  is_end;
   logic                  checksum_ok;
   logic                  length_error;
   logic [7:0]            data_byte;
   logic [7:0]            byte_index;
   logic [15:0]           sum_add;
   logic [15:0]           length_full;
   logic [15:0]           payload_last;
   logic [CountWidth-1:0] count_inc;

   assign sum_add      = sum_ff + 16'(rx_byte);
   assign length_full  = {length_ff[15:8], rx_byte};
   assign payload_last = length_ff - 16'd2;
   assign count_inc    = count_ff + CountWidth'(1);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      id_in         = id_ff;
      length_in     = length_ff;
      sum_in        = sum_ff;
      check_high_in = check_high_ff;
      hit_valid     = 1'b0;
      is_end        = 1'b0;
      checksum_ok   = 1'b0;
      length_error  = 1'b0;
      data_byte     = 8'd0;
      byte_index    = 8'd0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (rx_byte != ((count_ff == '0) ? header_first : header_second)) begin
               count_in = '0;
            end else if (count_ff == '0) begin
               count_in = count_inc;
            end else begin
               phase_in = PH_ADDR;
               count_in = '0;
            end
         end
         PH_ADDR: begin
            if (count_ff == CountWidth'(3)) begin
               phase_in = PH_ID;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_ID: begin
            id_in    = rx_byte;
            sum_in   = 16'(rx_byte);
            phase_in = PH_LENGTH;
            count_in = '0;
         end
         PH_LENGTH: begin
            sum_in = sum_add;
            if (count_ff == '0) begin
               length_in = {rx_byte, 8'h00};
               count_in  = CountWidth'(1);
            end else begin
               length_in = length_full;
               count_in  = '0;
               if (length_full < 16'd2 || 17'(length_full) > 17'(MAX_LENGTH)) begin
                  // bad length: report and go back to hunting
                  hit_valid    = 1'b1;
                  is_end       = 1'b1;
                  length_error = 1'b1;
                  phase_in     = PH_HEADER;
               end else if (length_full == 16'd2) begin
                  phase_in = PH_CHECK;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            sum_in     = sum_add;
            hit_valid  = 1'b1;
            data_byte  = rx_byte;
            byte_index = 8'(count_ff);
            if (16'(count_inc) >= payload_last) begin
               phase_in = PH_CHECK;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_CHECK: begin
            if (count_ff == '0) begin
               check_high_in = rx_byte;
               count_in      = CountWidth'(1);
            end else begin
               hit_valid   = 1'b1;
               is_end      = 1'b1;
               checksum_ok = ({check_high_ff, rx_byte} == sum_ff);
               phase_in    = PH_HEADER;
               count_in    = '0;
            end
         end
         default: begin
            phase_in = PH_HEADER;
            count_in = '0;
         end
      endcase
   end

   assign res_valid          = step & hit_valid;
   assign res.is_end         = is_end;
   assign res.packet_id      = id_in;
   assign res.data_byte      = data_byte;
   assign res.byte_index     = byte_index;
   assign res.payload_length = length_in;
   assign res.checksum_ok    = checksum_ok;
   assign res.length_error   = length_error;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         count_ff      <= '0;
         id_ff         <= 8'd0;
         length_ff     <= 16'd0;
         sum_ff        <= 16'd0;
         check_high_ff <= 8'd0;
      end else if (step) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         id_ff         <= id_in;
         length_ff     <= length_in;
         sum_ff        <= sum_in;
         check_high_ff <= check_high_in;
      end
   end

endmodule

`default_nettype wire

[design/sensor_reply_frame_parser.sv]
// ----------------------------------------------------------------------------
// sensor_reply_frame_parser: reply frame parser for a serial sensor link
// Takes received bytes, finds framed replies, emits payload bytes and a
// checksum or length error verdict at each frame end.
// ----------------------------------------------------------------------------
// usage
//   req channel: one received link byte per beat (req_valid / req_stall)
//   rsp channel: at most one result beat per request beat (rsp_valid /
//     rsp_stall); payload beats have rsp_is_end low, the frame end verdict
//     has rsp_is_end high with rsp_checksum_ok or rsp_length_error
//   csr port: header_first (index 0) and header_second (index 1), written
//     while the parser is idle
//   result register: a result appears on rsp in the cycle after its request beat is taken
//   throughput: one request beat per cycle while req_stall is low, set by the single result register
//   stall: req_stall rises only while a result waits and rsp_stall is high;
//     a waiting result is taken and a new byte accepted in the same cycle
//   reset: synchronous; parser returns to header hunt, headers go to
//     0xEF / 0x01, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_reply_frame_parser #(
   parameter int MAX_LENGTH = srfp_pkg::SRFP_MAX_LENGTH
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request beats
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire [7:0]                             req_rx_byte,
   // result beats
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_is_end,
   output logic [7:0]                            rsp_packet_id,
   output logic [7:0]                            rsp_data_byte,
   output logic [7:0]                            rsp_byte_index,
   output logic [15:0]                           rsp_payload_length,
   output logic                                  rsp_checksum_ok,
   output logic                                  rsp_length_error,
   // configuration writes
   input  wire                                   csr_write_enable,
   input  wire [srfp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire [7:0]                             csr_data
);
   import srfp_pkg::*;

   logic [7:0]  header_first_ff;
   logic [7:0]  header_second_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   logic        req_take;
   logic        res_valid;
   result_type  res;

   // header registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADER_FIRST:  header_first_ff  <= csr_data;
            CSR_HEADER_SECOND: header_second_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // hold off new bytes only while a result is blocked downstream
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   srfp_frame_fsm #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (req_take),
      .rx_byte       (req_rx_byte),
      .header_first  (header_first_ff),
      .header_second (header_second_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_end         = rsp_ff.is_end;
   assign rsp_packet_id      = rsp_ff.packet_id;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_byte_index     = rsp_ff.byte_index;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_checksum_ok    = rsp_ff.checksum_ok;
   assign rsp_length_error   = rsp_ff.length_error;

   // a stall on the request side only ever comes from a waiting result
   a_stall_has_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   // a new result never lands while the old one is blocked
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !res_valid)
      else $error("result register overwritten while stalled");

   // payload beats carry no verdict flags
   a_payload_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_end) |-> (!rsp_checksum_ok && !rsp_length_error))
      else $error("verdict flag on payload beat");

   // frame end beats carry zero data and index, and one verdict at most
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_end) |->
         (rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0 &&
          !(rsp_checksum_ok && rsp_length_error)))
      else $error("malformed frame end beat");

endmodule

`default_nettype wire
